// File: hw/rtl/csmp_pkg.sv
`timescale 1ns / 1ps

package csmp_pkg;

   localparam int CSMP_MAX_CATEGORIES = 256;
   localparam int CSMP_WEIGHT_BITS    = 16;
   localparam int CSMP_IN_BITS        = 16;
   localparam int CSMP_INDEX_BITS     = 8;

   typedef struct packed {
      logic [CSMP_IN_BITS-1:0] weight;
      logic [CSMP_IN_BITS-1:0] uniform;
      logic                    last;
   } csmp_req_type;

   typedef struct packed {
      logic [CSMP_INDEX_BITS-1:0] index;
      logic                       overflow;
   } csmp_rsp_type;

   typedef struct packed {
      logic go;
      logic overflow;
   } csmp_launch_type;

   typedef struct packed {
      logic busy;
      logic finish;
   } csmp_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_SEARCH
   } csmp_state_type;

endpackage

// File: hw/rtl/csmp_prefix_mem.sv
`timescale 1ns / 1ps

module csmp_prefix_mem
   import csmp_pkg::*;
#(
   parameter int DEPTH = CSMP_MAX_CATEGORIES,
   parameter int DW    = CSMP_WEIGHT_BITS + 8,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] store_mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/csmp_search.sv
`timescale 1ns / 1ps

module csmp_search
   import csmp_pkg::*;
#(
   parameter int MAX_CATEGORIES = CSMP_MAX_CATEGORIES,
   parameter int TW             = CSMP_WEIGHT_BITS + 8,
   localparam int AW            = $clog2(MAX_CATEGORIES),
   localparam int CW            = $clog2(MAX_CATEGORIES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  csmp_launch_type         launch,
   input  logic [CSMP_IN_BITS-1:0] uniform,
   input  logic [TW-1:0]           total,
   input  logic [CW-1:0]           count,
   output logic                    rd_en,
   output logic [AW-1:0]           rd_addr,
   input  logic [TW-1:0]           rd_data,
   output csmp_status_type         status,
   output logic                    rsp_strobe,
   output csmp_rsp_type            rsp_data
);

   localparam int PW = TW + CSMP_IN_BITS;

   csmp_state_type            state_ff, state_in;
   logic [CSMP_IN_BITS-1:0]   uniform_ff, uniform_in;
   logic [PW-1:0]             target_ff, target_in;
   logic [AW-1:0]             cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0]             last_idx_ff, last_idx_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   csmp_rsp_type              rsp_data_ff, rsp_data_in;
   logic                      hit;
   logic [AW-1:0]             count_last;

   assign count_last = AW'(count - CW'(1));
   assign hit        = {rd_data, {CSMP_IN_BITS{1'b0}}} >= target_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (launch.go) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (total == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (hit || cmp_idx_ff == last_idx_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      uniform_in    = uniform_ff;
      target_in     = target_ff;
      cmp_idx_in    = cmp_idx_ff;
      last_idx_in   = last_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      status.busy   = 1'b1;
      status.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            status.busy = 1'b0;
            if (launch.go) begin
               uniform_in = uniform;
            end
         end
         ST_PREP: begin
            target_in   = PW'(uniform_ff) * PW'(total);
            last_idx_in = count_last;
            cmp_idx_in  = '0;
            rd_en       = 1'b1;
            if (total == '0) begin
               status.finish        = 1'b1;
               rsp_strobe_in        = 1'b1;
               rsp_data_in.index    = CSMP_INDEX_BITS'(count_last);
               rsp_data_in.overflow = launch.overflow;
            end
         end
         ST_SEARCH: begin
            if (hit || cmp_idx_ff == last_idx_ff) begin
               status.finish        = 1'b1;
               rsp_strobe_in        = 1'b1;
               rsp_data_in.index    = CSMP_INDEX_BITS'(cmp_idx_ff);
               rsp_data_in.overflow = launch.overflow;
            end else begin
               cmp_idx_in = cmp_idx_ff + AW'(1);
               rd_en      = 1'b1;
               rd_addr    = cmp_idx_ff + AW'(1);
            end
         end
         default: status.busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      uniform_ff  <= uniform_in;
      target_ff   <= target_in;
      cmp_idx_ff  <= cmp_idx_in;
      last_idx_ff <= last_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff != ST_IDLE))
      else $error("Result strobe without a draw in progress.");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> state_ff == ST_IDLE)
      else $error("Result strobe while the search is still running.");

   a_go_when_idle: assert property (@(posedge clock) disable iff (reset)
      launch.go |-> state_ff == ST_IDLE)
      else $error("Draw launched while busy.");

   a_index_in_set: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> cmp_idx_ff <= last_idx_ff)
      else $error("Search walked past the last stored entry.");

endmodule

// File: hw/rtl/categorical_sampler_unit.sv
`timescale 1ns / 1ps

// Categorical sampler by inverse-CDF search.
// Input transactions are accepted on a rising edge where start is high and busy is low.
// Each transaction carries one weight; its running prefix sum goes into the prefix memory.
// A weight beyond MAX_CATEGORIES entries is dropped and sets the overflow flag.
// A transaction with last set also carries the uniform fraction and starts the draw.
// Transactions without last give no result and keep busy low for the next one.
// For a last transaction, busy is high while the block prepares the search and while it
// reads prefix entries in order up to the first one reaching uniform times the total;
// a zero total skips the search; the prefix memory read port walks one entry per cycle.
// The result appears on rsp_data, marked by rsp_strobe for exactly one cycle, in the
// cycle in which busy falls; a new transaction may be accepted in that same cycle.
// The receiver cannot stall the block; results are never held.
// After a draw the count, the total and the overflow flag return to zero.
// Reset is synchronous and active high and clears the same state; the prefix memory
// needs no clearing since only entries written in the current set are read.
module categorical_sampler_unit
   import csmp_pkg::*;
#(
   parameter int MAX_CATEGORIES = CSMP_MAX_CATEGORIES,
   parameter int WEIGHT_BITS    = CSMP_WEIGHT_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  csmp_req_type req_data,
   output logic         rsp_strobe,
   output csmp_rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_CATEGORIES);
   localparam int CW = $clog2(MAX_CATEGORIES + 1);
   localparam int TW = WEIGHT_BITS + AW;
   localparam logic [CSMP_IN_BITS-1:0] WMASK = (WEIGHT_BITS >= CSMP_IN_BITS) ?
      {CSMP_IN_BITS{1'b1}} : CSMP_IN_BITS'((64'd1 << WEIGHT_BITS) - 64'd1);

   logic [CW-1:0]   count_ff, count_in;
   logic [TW-1:0]   total_ff, total_in;
   logic            overflow_ff, overflow_in;
   logic            accept;
   logic [TW-1:0]   weight_eff;
   logic [TW-1:0]   sum;
   logic            wr_en;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic [TW-1:0]   rd_data;
   csmp_launch_type launch;
   csmp_status_type status;

   assign busy       = status.busy;
   assign accept     = start && !status.busy;
   assign weight_eff = TW'(req_data.weight & WMASK);
   assign sum        = total_ff + weight_eff;
   assign wr_en      = accept && (count_ff < CW'(MAX_CATEGORIES));

   always_comb begin
      count_in    = count_ff;
      total_in    = total_ff;
      overflow_in = overflow_ff;
      if (status.finish) begin
         count_in    = '0;
         total_in    = '0;
         overflow_in = 1'b0;
      end else if (accept) begin
         if (wr_en) begin
            count_in = count_ff + CW'(1);
            total_in = sum;
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         total_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         total_ff    <= total_in;
         overflow_ff <= overflow_in;
      end
   end

   assign launch.go       = accept && req_data.last;
   assign launch.overflow = overflow_ff;

   csmp_prefix_mem #(
      .DEPTH (MAX_CATEGORIES),
      .DW    (TW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (sum),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   csmp_search #(
      .MAX_CATEGORIES (MAX_CATEGORIES),
      .TW             (TW)
   ) u_search (
      .clock      (clock),
      .reset      (reset),
      .launch     (launch),
      .uniform    (req_data.uniform),
      .total      (total_ff),
      .count      (count_ff),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// File: tb/sv/categorical_sampler_checker.sv
`timescale 1ns / 1ps

module categorical_sampler_checker
   import csmp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  csmp_req_type req_data,
   input  logic         rsp_strobe,
   input  csmp_rsp_type rsp_data,
   output int           fail_count,
   output int           draws_pending
);

   logic [23:0]  prefix_sums [CSMP_MAX_CATEGORIES];
   int           set_count;
   logic [23:0]  set_total;
   logic         set_overflow;
   csmp_rsp_type expected_draws [$];

   initial begin
      fail_count    = 0;
      draws_pending = 0;
      set_count     = 0;
      set_total     = '0;
      set_overflow  = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   // The first prefix sum reaching uniform times the total, compared without division.
   function automatic logic [CSMP_INDEX_BITS-1:0] draw_category(input logic [15:0] u);
      logic [39:0] target;
      logic [39:0] scaled;
      int          pick;
      target = u * set_total;
      pick   = set_count - 1;
      if (set_total != 0) begin
         for (int i = set_count - 1; i >= 0; i--) begin
            scaled = {prefix_sums[i], 16'h0000};
            if (scaled >= target) begin
               pick = i;
            end
         end
      end
      return pick[CSMP_INDEX_BITS-1:0];
   endfunction

   function automatic void accept_weight(input csmp_req_type item);
      csmp_rsp_type draw;
      if (set_count < CSMP_MAX_CATEGORIES) begin
         set_total = set_total + item.weight[CSMP_WEIGHT_BITS-1:0];
         prefix_sums[set_count] = set_total;
         set_count++;
      end else begin
         set_overflow = 1'b1;
      end
      if (item.last) begin
         draw.index    = draw_category(item.uniform);
         draw.overflow = set_overflow;
         expected_draws.push_back(draw);
         set_count    = 0;
         set_total    = '0;
         set_overflow = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      csmp_rsp_type want;
      if (reset) begin
         set_count    = 0;
         set_total    = '0;
         set_overflow = 1'b0;
         expected_draws.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_draws.size() == 0) begin
               report_mismatch($sformatf("unexpected result index %0d overflow %0b",
                                         rsp_data.index, rsp_data.overflow));
            end else begin
               want = expected_draws.pop_front();
               if (rsp_data.index !== want.index) begin
                  report_mismatch($sformatf("index %0d, expected %0d",
                                            rsp_data.index, want.index));
               end
               if (rsp_data.overflow !== want.overflow) begin
                  report_mismatch($sformatf("overflow %0b, expected %0b",
                                            rsp_data.overflow, want.overflow));
               end
            end
         end
         if (start && !busy) begin
            accept_weight(req_data);
         end
      end
      draws_pending = expected_draws.size();
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import csmp_pkg::*;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   csmp_req_type req_data;
   logic         rsp_strobe;
   csmp_rsp_type rsp_data;
   int           fail_count;
   int           draws_pending;
   int           weights_sent;
   bit           no_gaps;

   categorical_sampler_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   categorical_sampler_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .draws_pending (draws_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_weight(input int style);
      case (style)
         0: begin
            return 16'h0000;
         end
         1: begin
            return 16'($urandom_range(0, 15));
         end
         2: begin
            return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
         end
         default: begin
            return 16'($urandom);
         end
      endcase
   endfunction

   function automatic logic [15:0] pick_uniform();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 16'h0000;
      end else if (r == 1) begin
         return 16'hFFFF;
      end
      return 16'($urandom);
   endfunction

   task automatic send_weight(input logic [15:0] w, input logic [15:0] u, input logic lst);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= '{weight: w, uniform: u, last: lst};
      @(posedge clock);
      while (busy) @(posedge clock);
      weights_sent++;
   endtask

   // Sends one set of weights; the final transaction carries the uniform fraction.
   task automatic send_set(input int length, input int style, input logic [15:0] u);
      for (int i = 0; i < length; i++) begin
         send_weight(pick_weight(style), (i == length - 1) ? u : 16'($urandom),
                     i == length - 1);
      end
   endtask

   initial begin
      int length;
      int r;
      start        = 1'b0;
      req_data     = '0;
      reset        = 1'b1;
      weights_sent = 0;
      no_gaps      = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero totals, full-scale weights and fractions, and an exact tie at the boundary.
      send_weight(16'h0000, 16'h0000, 1'b1);
      send_weight(16'h0000, 16'h1234, 1'b0);
      send_weight(16'h0000, 16'hFFFF, 1'b0);
      send_weight(16'h0000, 16'hFFFF, 1'b1);
      send_weight(16'hFFFF, 16'hFFFF, 1'b1);
      send_weight(16'h0001, 16'hFFFF, 1'b0);
      send_weight(16'hFFFF, 16'h0000, 1'b1);
      send_weight(16'h0000, 16'h0000, 1'b0);
      send_weight(16'h0000, 16'h0000, 1'b0);
      send_weight(16'h0007, 16'hFFFF, 1'b1);
      send_weight(16'hFFFF, 16'h0000, 1'b0);
      send_weight(16'hFFFF, 16'h5555, 1'b0);
      send_weight(16'h0001, 16'h8000, 1'b1);
      send_weight(16'h0005, 16'hAAAA, 1'b0);
      send_weight(16'h0000, 16'h0000, 1'b0);
      send_weight(16'h0005, 16'h8000, 1'b1);
      send_weight(16'h0000, 16'hFFFF, 1'b0);
      send_weight(16'h0000, 16'hFFFF, 1'b0);
      send_weight(16'h0001, 16'hFFFF, 1'b0);
      send_weight(16'h0000, 16'h0000, 1'b1);

      // A full set and an overflowing set first, then sets of mixed length.
      send_set(CSMP_MAX_CATEGORIES, 3, pick_uniform());
      send_set($urandom_range(CSMP_MAX_CATEGORIES + 1, CSMP_MAX_CATEGORIES + 6),
               $urandom_range(1, 3), pick_uniform());
      while (weights_sent < 1770) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 3) begin
            length = $urandom_range(CSMP_MAX_CATEGORIES - 4, CSMP_MAX_CATEGORIES + 6);
         end else if (r < 20) begin
            length = $urandom_range(17, 64);
         end else begin
            length = $urandom_range(1, 16);
         end
         r = $urandom_range(0, 19);
         send_set(length, (r == 0) ? 0 : (r < 5) ? 1 : (r < 8) ? 2 : 3, pick_uniform());
      end

      @(negedge clock);
      start <= 1'b0;
      while (draws_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
